[src/fpa_pkg.sv]
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 4;
    localparam int FPA_FRAC_BITS = 8;
    localparam int FPA_WORD_BITS = 32;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              less;
        logic              equal;
        logic              greater;
        logic              ovf;
        logic              dz;
    } t_res;

    typedef struct packed {
        t_kind             kind;
        logic              neg;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        t_res              r;
    } t_op;

endpackage

[src/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU.
// The ALU takes one item per cycle while full is low and returns one result per item, in
// order. Add, subtract, min, max, increment, decrement and the integer conversions are done
// in the front stage; multiply and divide run in a back-end pipeline whose length is set by
// the one-bit-per-stage restoring divider, and every item passes through it on its way to
// the result queue. Multiply and divide round to nearest with ties away from zero, overflow
// saturates, and divide by zero is flagged.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FPA_FRAC_BITS,
    parameter int WORD_BITS = FPA_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] o_result,
    output logic              o_a_less,
    output logic              o_a_equal,
    output logic              o_a_greater,
    output logic              o_overflow,
    output logic              o_divide_by_zero
);
    logic f_valid, q_full, q_empty, q_pop, b_push, o_full_q;
    t_op  f_op, q_op;
    t_res b_res, o_res;

    fpa_front #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_command(i_command), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_full(full), .o_valid(f_valid), .o_op(f_op), .i_q_full(q_full)
    );

    fpa_fifo #(.WIDTH($bits(t_op)), .DEPTH(FIFO_DEPTH)) u_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid), .i_data(f_op),
        .o_full(q_full), .i_pop(q_pop), .o_data(q_op), .o_empty(q_empty)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .i_op(q_op),
        .o_q_pop(q_pop), .i_out_full(o_full_q), .o_push(b_push), .o_res(b_res)
    );

    fpa_fifo #(.WIDTH($bits(t_res)), .DEPTH(FIFO_DEPTH)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(b_push), .i_data(b_res),
        .o_full(o_full_q), .i_pop(pop), .o_data(o_res), .o_empty(empty)
    );

    assign o_result         = o_res.res;
    assign o_a_less         = o_res.less;
    assign o_a_equal        = o_res.equal;
    assign o_a_greater      = o_res.greater;
    assign o_overflow       = o_res.ovf;
    assign o_divide_by_zero = o_res.dz;
endmodule

[src/fpa_fifo.sv]
// Small synchronous queue with full and empty flags.
module fpa_fifo
    import fpa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

[src/fpa_front.sv]
// Front stage: decodes each item, computes compares and the operations that need no back end.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FPA_FRAC_BITS,
    parameter int WORD_BITS = FPA_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output logic              o_full,
    output logic              o_valid,
    output t_op               o_op,
    input  logic              i_q_full
);
    localparam int E = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
    localparam logic signed [63:0] WMAX = (64'sd1 <<< (E-1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

    function automatic logic [DATA_W:0] sat(input logic signed [63:0] v);
        logic [DATA_W:0] o;
        if (v > WMAX) begin
            o = {1'b1, WMAX[DATA_W-1:0]};
        end else if (v < WMIN) begin
            o = {1'b1, WMIN[DATA_W-1:0]};
        end else begin
            o = {1'b0, v[DATA_W-1:0]};
        end
        return o;
    endfunction

    logic signed [63:0] a_x, b_x, mag_a, mag_b;
    logic [DATA_W:0]    s;
    t_op                n_op, r_op;
    logic               r_valid, load;

    always_comb begin
        a_x   = $signed(i_operand_a[E-1:0]);
        b_x   = $signed(i_operand_b[E-1:0]);
        mag_a = a_x[63] ? -a_x : a_x;
        mag_b = b_x[63] ? -b_x : b_x;
        s     = '0;
        n_op  = '0;
        n_op.kind      = K_SIMPLE;
        n_op.neg       = a_x[63] ^ b_x[63];
        n_op.mag_a     = mag_a[DATA_W-1:0];
        n_op.mag_b     = mag_b[DATA_W-1:0];
        n_op.r.less    = a_x < b_x;
        n_op.r.equal   = a_x == b_x;
        n_op.r.greater = a_x > b_x;
        case (i_command)
            CMD_ADD:      s = sat(a_x + b_x);
            CMD_SUB:      s = sat(a_x - b_x);
            CMD_MUL:      n_op.kind = K_MUL;
            CMD_DIV: begin
                if (b_x != 64'sd0) begin
                    n_op.kind = K_DIV;
                end else begin
                    n_op.r.dz = 1'b1;
                    if (a_x > 64'sd0) begin
                        s = {1'b1, WMAX[DATA_W-1:0]};
                    end else if (a_x < 64'sd0) begin
                        s = {1'b1, WMIN[DATA_W-1:0]};
                    end
                end
            end
            CMD_MIN:      s = {1'b0, (a_x < b_x) ? a_x[DATA_W-1:0] : b_x[DATA_W-1:0]};
            CMD_MAX:      s = {1'b0, (a_x > b_x) ? a_x[DATA_W-1:0] : b_x[DATA_W-1:0]};
            CMD_INC:      s = sat(a_x + 64'sd1);
            CMD_DEC:      s = sat(a_x - 64'sd1);
            CMD_TO_INT:   s = {1'b0, DATA_W'(a_x >>> FRAC_BITS)};
            CMD_FROM_INT: s = sat(a_x <<< FRAC_BITS);
            default:      s = '0;
        endcase
        n_op.r.ovf = s[DATA_W];
        n_op.r.res = s[DATA_W-1:0];
    end

    assign load    = !r_valid || !i_q_full;
    assign o_full  = r_valid && i_q_full;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_push) begin
            r_op <= n_op;
        end
    end
endmodule

[src/fpa_back.sv]
// Back end: pipelined multiplier and restoring divider with rounding and saturation.
module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FPA_FRAC_BITS,
    parameter int WORD_BITS = FPA_WORD_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_op  i_op,
    output logic o_q_pop,
    input  logic i_out_full,
    output logic o_push,
    output t_res o_res
);
    localparam int E  = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
    localparam int QW = E + FRAC_BITS;
    localparam logic [63:0] WMAX = (64'd1 << (E-1)) - 64'd1;
    localparam logic [63:0] WMIN = ~WMAX;

    typedef struct packed {
        t_op           op;
        logic [E-1:0]  rem;
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
        logic [63:0]   prod;
    } t_stage;

    function automatic logic [DATA_W:0] sat_mag(input logic [63:0] q, input logic neg);
        logic [DATA_W:0] o;
        logic [63:0]     nq;
        nq = -q;
        if (!neg) begin
            o = (q > WMAX) ? {1'b1, WMAX[DATA_W-1:0]} : {1'b0, q[DATA_W-1:0]};
        end else begin
            o = (q > WMAX + 64'd1) ? {1'b1, WMIN[DATA_W-1:0]} : {1'b0, nq[DATA_W-1:0]};
        end
        return o;
    endfunction

    t_stage r_s [QW+1];
    logic   r_v [QW+1];
    logic   en;

    assign en      = !i_out_full;
    assign o_q_pop = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s[0].op   <= i_op;
            r_s[0].rem  <= '0;
            r_s[0].num  <= {i_op.mag_a[E-1:0], {FRAC_BITS{1'b0}}};
            r_s[0].quo  <= '0;
            r_s[0].prod <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        t_stage       n_s;
        logic [E:0]   t;
        logic         ge;
        logic [DATA_W:0] m;
        logic [63:0]  rq;

        always_comb begin
            n_s = r_s[k];
            t   = {r_s[k].rem, r_s[k].num[QW-1]};
            ge  = t >= {1'b0, r_s[k].op.mag_b[E-1:0]};
            rq  = (r_s[k].prod + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
            m   = sat_mag(rq, r_s[k].op.neg);
            n_s.rem = ge ? E'(t - {1'b0, r_s[k].op.mag_b[E-1:0]}) : t[E-1:0];
            n_s.num = {r_s[k].num[QW-2:0], 1'b0};
            n_s.quo = {r_s[k].quo[QW-2:0], ge};
            if (k == 0) begin
                n_s.prod = 64'(r_s[k].op.mag_a) * 64'(r_s[k].op.mag_b);
            end
            if (k == 1 && r_s[k].op.kind == K_MUL) begin
                n_s.op.r.ovf = m[DATA_W];
                n_s.op.r.res = m[DATA_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en && r_v[k]) begin
                r_s[k+1] <= n_s;
            end
        end
    end

    logic [63:0]     dq;
    logic [DATA_W:0] dm;

    always_comb begin
        dq = 64'(r_s[QW].quo)
           + 64'(({r_s[QW].rem, 1'b0} >= {1'b0, r_s[QW].op.mag_b[E-1:0]}) ? 1 : 0);
        dm = sat_mag(dq, r_s[QW].op.neg);
        o_res = r_s[QW].op.r;
        if (r_s[QW].op.kind == K_DIV) begin
            o_res.ovf = dm[DATA_W];
            o_res.res = dm[DATA_W-1:0];
        end
    end

    assign o_push = en && r_v[QW];

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW] && r_s[QW].op.kind == K_DIV |-> !r_s[QW].op.r.dz)
        else $error("divide by zero reached the divider");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW] && r_s[QW].op.kind == K_DIV |-> r_s[QW].rem < r_s[QW].op.mag_b[E-1:0])
        else $error("divider remainder out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_v[QW] == $past(r_v[QW]))
        else $error("pipeline moved while stalled");
endmodule
